/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("assertion failed: forbidden condition");

`endif

/* rtl/fmd_pkg.sv */
// ----------------------------------------------------------------------------
// fmd_pkg
// Beat types, header layout, status codes and the CRC-16/CCITT-FALSE byte
// update for the framed message decoder.
// ----------------------------------------------------------------------------
package fmd_pkg;

  // Frame layout
  localparam int HEADER_BYTES = 10;
  localparam int MAX_PAYLOAD  = 256;

  // Header byte positions
  localparam logic [3:0] HDR_MAGIC0  = 4'd0;
  localparam logic [3:0] HDR_MAGIC1  = 4'd1;
  localparam logic [3:0] HDR_VERSION = 4'd2;
  localparam logic [3:0] HDR_TYPE    = 4'd3;
  localparam logic [3:0] HDR_FLAGS   = 4'd4;
  localparam logic [3:0] HDR_SEQ_LO  = 4'd6;
  localparam logic [3:0] HDR_SEQ_HI  = 4'd7;
  localparam logic [3:0] HDR_LEN_LO  = 4'd8;
  localparam logic [3:0] HDR_LEN_HI  = 4'd9;

  localparam logic [7:0] MAGIC_FIRST  = 8'h51;
  localparam logic [7:0] MAGIC_SECOND = 8'h47;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Byte counter saturation value
  localparam logic [15:0] POS_MAX = 16'hFFFF;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_LENGTH  = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
  localparam logic [2:0] ST_BAD_VERSION = 3'd3;
  localparam logic [2:0] ST_CRC_ERROR   = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [7:0]  msg_type;
    logic [7:0]  frame_flags;
    logic [15:0] sequence_res;
    logic [8:0]  body_len;
  } out_beat_t;

  // One byte through the MSB-first CRC, eight shift steps unrolled
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* rtl/fmd_parser.sv */
// ----------------------------------------------------------------------------
// fmd_parser
// Per-frame state and combinational decode of one byte: header capture, CRC
// update, payload pass-through and the end-of-buffer status.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fmd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  fmd_pkg::in_beat_t  beat,
  input  logic [7:0]         version,
  output logic               res_valid,
  output fmd_pkg::out_beat_t res
);
  import fmd_pkg::*;

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] rcrc_r, rcrc_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic        magic_err_r, magic_err_nxt;
  logic        ver_err_r, ver_err_nxt;

  logic [7:0]  b;
  logic [16:0] pos_ext;
  logic [16:0] crc_pos;
  logic [16:0] n;
  logic        in_header;
  logic        in_payload;
  logic        len_bad;
  logic [2:0]  st;

  assign b         = beat.rx_byte;
  assign pos_ext   = {1'b0, pos_r};
  assign crc_pos   = 17'(HEADER_BYTES) + {1'b0, len_r};
  assign in_header = pos_r < 16'(HEADER_BYTES);
  assign in_payload = !in_header && (pos_ext < crc_pos);

  // Next frame state for this byte
  always_comb begin
    crc_nxt       = crc_r;
    rcrc_nxt      = rcrc_r;
    len_nxt       = len_r;
    type_nxt      = type_r;
    flags_nxt     = flags_r;
    seq_nxt       = seq_r;
    magic_err_nxt = magic_err_r;
    ver_err_nxt   = ver_err_r;
    if (in_header) begin
      crc_nxt = crc16_byte(crc_r, b);
      unique case (pos_r[3:0])
        HDR_MAGIC0:  magic_err_nxt = magic_err_r | (b != MAGIC_FIRST);
        HDR_MAGIC1:  magic_err_nxt = magic_err_r | (b != MAGIC_SECOND);
        HDR_VERSION: ver_err_nxt   = ver_err_r | (b != version);
        HDR_TYPE:    type_nxt      = b;
        HDR_FLAGS:   flags_nxt     = b;
        HDR_SEQ_LO:  seq_nxt       = {8'h00, b};
        HDR_SEQ_HI:  seq_nxt       = {b, seq_r[7:0]};
        HDR_LEN_LO:  len_nxt       = {8'h00, b};
        HDR_LEN_HI:  len_nxt       = {b, len_r[7:0]};
        default:     ;
      endcase
    end else if (in_payload) begin
      crc_nxt = crc16_byte(crc_r, b);
    end else if (pos_ext == crc_pos) begin
      rcrc_nxt = {8'h00, b};
    end else if (pos_ext == crc_pos + 17'd1) begin
      rcrc_nxt = {b, rcrc_r[7:0]};
    end
    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 16'd1;
  end

  // End-of-buffer status, by priority
  assign n       = pos_ext + 17'd1;
  assign len_bad = len_nxt > 16'(MAX_PAYLOAD);

  always_comb begin
    priority if (n < 17'(HEADER_BYTES + 2)) begin
      st = ST_BAD_LENGTH;
    end else if (magic_err_nxt) begin
      st = ST_BAD_MAGIC;
    end else if (ver_err_nxt) begin
      st = ST_BAD_VERSION;
    end else if (len_bad) begin
      st = ST_BAD_LENGTH;
    end else if (n != 17'(HEADER_BYTES) + {1'b0, len_nxt} + 17'd2) begin
      st = ST_BAD_LENGTH;
    end else if (crc_nxt != rcrc_nxt) begin
      st = ST_CRC_ERROR;
    end else begin
      st = ST_OK;
    end
  end

  // Result beat: status on the last byte, else a tentative payload byte
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (beat.last) begin
      res_valid     = 1'b1;
      res.is_status = 1'b1;
      res.status    = st;
      if (st == ST_OK) begin
        res.msg_type     = type_nxt;
        res.frame_flags  = flags_nxt;
        res.sequence_res = seq_nxt;
        res.body_len     = len_nxt[8:0];
      end
    end else if (in_payload && !magic_err_nxt && !ver_err_nxt && !len_bad) begin
      res_valid        = 1'b1;
      res.payload_byte = b;
    end
  end

  // Frame state; the last byte of a buffer returns it to the reset values
  always_ff @(posedge clk) begin
    if (!rst_n || (step && beat.last)) begin
      pos_r       <= '0;
      crc_r       <= CRC_INIT;
      rcrc_r      <= '0;
      len_r       <= '0;
      type_r      <= '0;
      flags_r     <= '0;
      seq_r       <= '0;
      magic_err_r <= 1'b0;
      ver_err_r   <= 1'b0;
    end else if (step) begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      rcrc_r      <= rcrc_nxt;
      len_r       <= len_nxt;
      type_r      <= type_nxt;
      flags_r     <= flags_nxt;
      seq_r       <= seq_nxt;
      magic_err_r <= magic_err_nxt;
      ver_err_r   <= ver_err_nxt;
    end
  end

  `ASSERT_NEXT(a_last_clears, clk, rst_n, step && beat.last, pos_r == '0 && crc_r == CRC_INIT)
  `ASSERT_NEXT(a_pos_counts, clk, rst_n, step && !beat.last && pos_r != POS_MAX,
               pos_r == $past(pos_r) + 16'd1)
  `ASSERT_IMPL(a_magic_after_hdr, clk, rst_n, magic_err_r, pos_r != '0)
  `ASSERT_IMPL(a_ver_after_hdr, clk, rst_n, ver_err_r, pos_r > 16'd2)

endmodule

/* rtl/framed_message_decoder_crc16.sv */
// ----------------------------------------------------------------------------
// framed_message_decoder_crc16
// Byte-stream decoder for a framed message with a CRC-16/CCITT-FALSE trailer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one buffer byte per beat; in_data.last marks the buffer's final byte.
//   out_* : a tentative payload beat per payload byte (is_status = 0) while no
//           header error is known, and one status beat (is_status = 1) on the
//           last byte, carrying the header fields when the status is ok.
//   cfg_* : cfg_we writes cfg_wdata into the expected protocol version; write
//           it only while no buffer is in flight.
//   An accepted beat lands in the input register; its result is loaded into
//   the result register when the input register advances and can be taken
//   from there. Throughput is one byte per cycle while no stall holds, bounded
//   by the byte-wide CRC update that feeds back into the running CRC register.
//   Reset (rst_n low, synchronous) empties both registers, clears the frame
//   state and sets the expected version to 1.
//   When out_stall is high with a result waiting, the input register holds
//   one more byte; in_stall rises only once that register is full too.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module framed_message_decoder_crc16 (
  input  logic               clk,
  input  logic               rst_n,
  // Input byte channel
  input  logic               in_valid,
  output logic               in_stall,
  input  fmd_pkg::in_beat_t  in_data,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output fmd_pkg::out_beat_t out_data,
  // Configuration
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);
  import fmd_pkg::*;

  logic       s1_valid_r;
  in_beat_t   s1_data_r;
  logic       out_valid_r;
  out_beat_t  out_data_r;
  logic [7:0] version_r;
  logic       s1_adv;
  logic       step;
  logic       res_valid;
  out_beat_t  res;

  // Input register advances when the result register is free or draining
  assign s1_adv   = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;

  // Expected protocol version
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= 8'd1;
    end else if (cfg_we) begin
      version_r <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  fmd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .beat      (s1_data_r),
    .version   (version_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPL(a_stall_needs_item, clk, rst_n, in_stall, s1_valid_r && out_valid_r)
  `ASSERT_IMPL(a_payload_beat_clean, clk, rst_n, out_valid_r && !out_data_r.is_status,
               out_data_r.status == ST_OK && out_data_r.body_len == '0)
  `ASSERT_IMPL(a_bad_status_no_hdr, clk, rst_n,
               out_valid_r && out_data_r.is_status && out_data_r.status != ST_OK,
               out_data_r.sequence_res == '0 && out_data_r.msg_type == '0)

endmodule

/* sim/framed_message_decoder_crc16_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// framed_message_decoder_crc16_test
// Streams framed buffers into the decoder one byte per beat: well-formed
// frames with random content, plus frames with bad magic, version, CRC,
// size or truncation, oversize lengths, short buffers and raw noise. A
// byte-level decoder in the bench predicts every payload and status beat,
// and the monitor compares each one field by field, in order.
// ----------------------------------------------------------------------------
module framed_message_decoder_crc16_test;
  import fmd_pkg::*;

  localparam int GAP_PCT      = 24;    // idle / stall chance per cycle
  localparam int SETTLE_CYCLES = 10;   // margin past the two-stage latency
  localparam int STUCK_LIMIT  = 2000;  // cycles without any handshake

  typedef enum {
    FRAME_GOOD,
    FRAME_BAD_MAGIC,
    FRAME_BAD_VERSION,
    FRAME_BAD_CRC,
    FRAME_CUT,
    FRAME_TRAILING,
    FRAME_SHORT,
    FRAME_OVERSIZE,
    FRAME_NOISE
  } frame_kind_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_beat_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_beat_t  out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;

  // Bench control
  in_beat_t  bytes_to_send[$];
  out_beat_t decoded_due[$];
  int        queued_beats = 0;
  int        errors = 0;
  int        stuck_cycles = 0;
  logic      calm = 1'b0;        // no idling on either side
  logic      hold_input = 1'b0;  // sender pause

  // Predicted decoder state
  logic [7:0]  version_reg;
  logic [15:0] frame_pos;
  logic [15:0] frame_crc;
  logic [15:0] trailer_crc;
  logic [15:0] hdr_length;
  logic [7:0]  hdr_type;
  logic [7:0]  hdr_flags;
  logic [15:0] hdr_seq;
  logic        magic_bad;
  logic        version_bad;

  framed_message_decoder_crc16 u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // CRC-16/CCITT-FALSE, one message bit at a time, MSB first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic fb;
    int   i;
    for (i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return crc;
  endfunction

  function automatic void clear_frame();
    frame_pos   = '0;
    frame_crc   = CRC_INIT;
    trailer_crc = '0;
    hdr_length  = '0;
    hdr_type    = '0;
    hdr_flags   = '0;
    hdr_seq     = '0;
    magic_bad   = 1'b0;
    version_bad = 1'b0;
  endfunction

  // Decode one accepted byte and queue the beat it should produce, if any
  function automatic void decode_byte(input in_beat_t beat);
    out_beat_t   res;
    logic [15:0] p;
    logic [7:0]  b;
    int          crc_at;
    int          n;
    logic        pay;
    logic        len_bad;
    logic [2:0]  st;
    p      = frame_pos;
    b      = beat.rx_byte;
    crc_at = HEADER_BYTES + hdr_length;
    pay    = 1'b0;
    res    = '0;

    if (p < HEADER_BYTES) begin
      frame_crc = crc_step(frame_crc, b);
      case (p)
        HDR_MAGIC0:  if (b != MAGIC_FIRST) magic_bad = 1'b1;
        HDR_MAGIC1:  if (b != MAGIC_SECOND) magic_bad = 1'b1;
        HDR_VERSION: if (b != version_reg) version_bad = 1'b1;
        HDR_TYPE:    hdr_type = b;
        HDR_FLAGS:   hdr_flags = b;
        HDR_SEQ_LO:  hdr_seq = {8'h00, b};
        HDR_SEQ_HI:  hdr_seq[15:8] = b;
        HDR_LEN_LO:  hdr_length = {8'h00, b};
        HDR_LEN_HI:  hdr_length[15:8] = b;
        default: ;
      endcase
    end else if (p < crc_at) begin
      frame_crc = crc_step(frame_crc, b);
      pay = 1'b1;
    end else if (p == crc_at) begin
      trailer_crc = {8'h00, b};
    end else if (p == crc_at + 1) begin
      trailer_crc[15:8] = b;
    end

    if (p < POS_MAX) frame_pos = p + 16'd1;
    len_bad = hdr_length > MAX_PAYLOAD;

    if (!beat.last) begin
      // tentative payload beat unless a header error is already known
      if (pay && !magic_bad && !version_bad && !len_bad) begin
        res.payload_byte = b;
        decoded_due.push_back(res);
      end
    end else begin
      n = int'(p) + 1;
      if (n < HEADER_BYTES + 2)                      st = ST_BAD_LENGTH;
      else if (magic_bad)                            st = ST_BAD_MAGIC;
      else if (version_bad)                          st = ST_BAD_VERSION;
      else if (len_bad)                              st = ST_BAD_LENGTH;
      else if (n != HEADER_BYTES + hdr_length + 2)   st = ST_BAD_LENGTH;
      else if (frame_crc != trailer_crc)             st = ST_CRC_ERROR;
      else                                           st = ST_OK;
      res.is_status = 1'b1;
      res.status    = st;
      if (st == ST_OK) begin
        res.msg_type     = hdr_type;
        res.frame_flags  = hdr_flags;
        res.sequence_res = hdr_seq;
        res.body_len     = hdr_length[8:0];
      end
      decoded_due.push_back(res);
      clear_frame();
    end
  endfunction

  function automatic void check_field(input string field, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  // Header bytes lean toward their extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] flip_mask();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic void queue_beat(input logic [7:0] b, input logic last);
    in_beat_t beat;
    beat.rx_byte = b;
    beat.last    = last;
    bytes_to_send.push_back(beat);
    queued_beats++;
  endfunction

  // Build one buffer. adjust: trailing or body byte count for trailing,
  // oversize and noise buffers; kept byte count for short ones (0 = random).
  function automatic void queue_frame(input frame_kind_t kind, input int pay_len,
                                      input int adjust);
    logic [7:0]  octets[$];
    logic [15:0] crc;
    logic [15:0] len_word;
    int          keep;
    int          idx;
    len_word = pay_len[15:0];
    if (kind == FRAME_OVERSIZE) begin
      case ($urandom_range(3))
        0:       len_word = MAX_PAYLOAD + 1;
        1:       len_word = 16'hFFFF;
        default: len_word = 16'($urandom_range(MAX_PAYLOAD + 1, 16'hFFFF));
      endcase
    end

    if (kind == FRAME_NOISE) begin
      repeat (adjust) octets.push_back(8'($urandom));
    end else begin
      octets.push_back(MAGIC_FIRST);
      octets.push_back(MAGIC_SECOND);
      octets.push_back(version_reg);
      octets.push_back(pick_byte());   // type
      octets.push_back(pick_byte());   // flags
      octets.push_back(pick_byte());   // reserved
      octets.push_back(pick_byte());   // sequence, low first
      octets.push_back(pick_byte());
      octets.push_back(len_word[7:0]);
      octets.push_back(len_word[15:8]);

      // header faults go in before the CRC so only the intended error shows
      if (kind == FRAME_BAD_MAGIC) begin
        octets[$urandom_range(1)] ^= flip_mask();
        if ($urandom_range(2) == 0) octets[HDR_VERSION] ^= flip_mask();
      end
      if (kind == FRAME_BAD_VERSION) octets[HDR_VERSION] ^= flip_mask();
      if (kind == FRAME_SHORT && $urandom_range(2) == 0) octets[HDR_MAGIC0] ^= flip_mask();

      if (kind == FRAME_OVERSIZE) begin
        repeat (adjust) octets.push_back(8'($urandom));
      end else begin
        repeat (pay_len) octets.push_back(8'($urandom));
        crc = CRC_INIT;
        foreach (octets[i]) crc = crc_step(crc, octets[i]);
        octets.push_back(crc[7:0]);
        octets.push_back(crc[15:8]);
      end
    end

    // trailer-side faults
    keep = octets.size();
    case (kind)
      FRAME_BAD_CRC: begin
        idx = $urandom_range(HDR_TYPE, octets.size() - 1);
        if (idx == HDR_LEN_LO || idx == HDR_LEN_HI) idx = octets.size() - 1;
        octets[idx] ^= 8'(1 << $urandom_range(7));
      end
      FRAME_CUT:      keep = $urandom_range(1, octets.size() - 1);
      FRAME_SHORT:    keep = adjust != 0 ? adjust : $urandom_range(1, HEADER_BYTES + 1);
      FRAME_TRAILING: repeat (adjust) octets.push_back(8'($urandom));
      default: ;
    endcase
    if (kind != FRAME_TRAILING) begin
      while (octets.size() > keep) void'(octets.pop_back());
    end

    foreach (octets[i]) queue_beat(octets[i], i == octets.size() - 1);
  endfunction

  // Mostly well-formed frames with small payloads, the rest broken or noise
  function automatic void queue_random_frames(input int upto);
    frame_kind_t kind;
    int          r;
    int          pay_len;
    int          adjust;
    while (queued_beats < upto) begin
      r = $urandom_range(99);
      if (r < 60)      kind = FRAME_GOOD;
      else if (r < 65) kind = FRAME_BAD_MAGIC;
      else if (r < 70) kind = FRAME_BAD_VERSION;
      else if (r < 77) kind = FRAME_BAD_CRC;
      else if (r < 82) kind = FRAME_CUT;
      else if (r < 87) kind = FRAME_TRAILING;
      else if (r < 91) kind = FRAME_SHORT;
      else if (r < 95) kind = FRAME_OVERSIZE;
      else             kind = FRAME_NOISE;

      r = $urandom_range(99);
      if (r < 88)      pay_len = $urandom_range(0, 24);
      else if (r < 97) pay_len = $urandom_range(25, MAX_PAYLOAD);
      else             pay_len = MAX_PAYLOAD;

      case (kind)
        FRAME_TRAILING: adjust = $urandom_range(1, 6);
        FRAME_OVERSIZE: adjust = $urandom_range(0, 20);
        FRAME_NOISE:    adjust = $urandom_range(1, 24);
        default:        adjust = 0;
      endcase
      queue_frame(kind, pay_len, adjust);
    end
  endfunction

  // Everything sent, every result back, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    while (bytes_to_send.size() != 0 || in_valid || decoded_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_version(input logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    version_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Input driver: a stalled beat holds; otherwise load the next or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_byte(in_data);
      if (!in_valid || !in_stall) begin
        if (bytes_to_send.size() != 0 && !hold_input &&
            (calm || $urandom_range(99) >= GAP_PCT)) begin
          in_data  <= bytes_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and random back-pressure
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, got %h", $time, out_data);
        end else begin
          want = decoded_due.pop_front();
          check_field("is_status",    want.is_status,    out_data.is_status);
          check_field("payload_byte", want.payload_byte, out_data.payload_byte);
          check_field("status",       want.status,       out_data.status);
          check_field("msg_type",     want.msg_type,     out_data.msg_type);
          check_field("frame_flags",  want.frame_flags,  out_data.frame_flags);
          check_field("sequence_res", want.sequence_res, out_data.sequence_res);
          check_field("body_len",     want.body_len,     out_data.body_len);
        end
      end
      out_stall <= !calm && ($urandom_range(99) < GAP_PCT);
    end
  end

  // Watchdog: no beat moving on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int half;
    version_reg = 8'd1;
    clear_frame();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // one-byte buffer, a buffer one byte short, an empty-payload frame
    queue_beat(8'h00, 1'b1);
    queue_frame(FRAME_SHORT, 0, HEADER_BYTES + 1);
    queue_frame(FRAME_GOOD, 0, 0);
    queue_random_frames(250);
    wait_idle();

    set_version(8'h00);
    queue_random_frames(450);
    wait_idle();

    // back-to-back stretch at the top version value
    calm <= 1'b1;
    set_version(8'hFF);
    queue_random_frames(650);
    wait_idle();

    calm <= 1'b0;
    set_version(8'($urandom_range(2, 254)));
    queue_random_frames(1100);

    // halfway through, hold the sender until the decoder has drained
    half = bytes_to_send.size() / 2;
    while (bytes_to_send.size() > half) @(negedge clk);
    @(posedge clk);
    hold_input <= 1'b1;
    @(negedge clk);
    while (in_valid || decoded_due.size() != 0) @(negedge clk);
    @(posedge clk);
    hold_input <= 1'b0;
    wait_idle();

    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
